/* rtl/core/next_prime_search_top_assert.svh */
// Assertion macros for the next prime search block.
// Used by next_prime_search_top; expects clk_i and rst_ni in scope.
`ifndef NEXT_PRIME_SEARCH_TOP_ASSERT_SVH
`define NEXT_PRIME_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nps_pkg.sv */
// Shared types and constants for the next prime search block.
// No dependencies; used by every module under rtl/core.
package nps_pkg;

  localparam int unsigned ValueW  = 31;  // start value and result width
  localparam int unsigned DivW    = 16;  // trial divisor width, covers sqrt(2^31) + 2
  localparam int unsigned SqW     = 2 * DivW;
  localparam int unsigned RemCntW = 5;   // counts the ValueW dividend bits

  localparam logic [ValueW-1:0]  FirstPrime  = ValueW'(2);
  localparam logic [DivW-1:0]    FirstOddDiv = DivW'(3);
  localparam logic [DivW-1:0]    DivStep     = DivW'(2);
  localparam logic [RemCntW-1:0] RemSteps    = RemCntW'(ValueW);

  typedef logic [ValueW-1:0] value_t;
  typedef logic [DivW-1:0]   divisor_t;

  typedef enum logic [2:0] {
    NpsIdle,
    NpsCheck,
    NpsBound,
    NpsDivide,
    NpsFound
  } nps_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_start;
    logic next_cand;
    logic init_div;
    logic step_div;
    logic start_rem;
    logic load_out;
  } nps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand_lt2;
    logic cand_is2;
    logic cand_even;
    logic over_bound;
    logic rem_done;
    logic rem_zero;
  } nps_stat_t;

endpackage

/* rtl/core/next_prime_search_top.sv */
// Channel  | Handshake                   | Payload
// input    | in_valid_i / in_stall_o     | in_start_value_i  (31 bit)
// output   | out_valid_o / out_stall_i   | out_prime_o       (31 bit)
//
// One item at a time. Per candidate: a check state, then per odd trial divisor
// a bound state plus one division in the bit-serial remainder unit; composites
// usually exit early. The remainder unit dominates the run time. Reset is
// asynchronous, active low; no clearing pass. A result waits in the output
// register while the next item is taken.
// Top level of the next prime search block; depends on nps_pkg, nps_ctrl, nps_dpath.
module next_prime_search_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [30:0]            in_start_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [30:0]            out_prime_o
);

  nps_pkg::nps_cmd_t  cmd;
  nps_pkg::nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  nps_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_value_i (in_start_value_i),
    .prime_o       (out_prime_o)
  );

`include "next_prime_search_top_assert.svh"

  // A taken item blocks the input until its search ends
  `NPS_ASSERT_NEXT(a_busy_accept, in_valid_i && !in_stall_o, in_stall_o, "input open")

  // A result is 2 or odd
  `NPS_ASSERT_NOW(a_result_odd, out_valid_o, out_prime_o == 31'd2 || out_prime_o[0], "even result")

  // A fresh division cannot report done on the next cycle
  `NPS_ASSERT_NEXT(a_rem_latency, cmd.start_rem, !stat.rem_done, "remainder done too early")

endmodule

/* rtl/core/nps_rem_unit.sv */
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
// Depends on nps_pkg.
module nps_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nps_pkg::value_t   dividend_i,
  input  nps_pkg::divisor_t divisor_i,
  output logic              done_o,
  output nps_pkg::divisor_t rem_o
);

  nps_pkg::value_t               dvd_q;
  nps_pkg::divisor_t             dsr_q;
  nps_pkg::divisor_t             rem_q;
  logic [nps_pkg::RemCntW-1:0]   cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [nps_pkg::DivW:0] trial;
  logic [nps_pkg::DivW:0] diff;
  logic                   fits;

  // Shift next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_q, dvd_q[nps_pkg::ValueW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nps_pkg::RemSteps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == nps_pkg::RemCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[nps_pkg::ValueW-2:0], 1'b0};
      rem_q <= fits ? diff[nps_pkg::DivW-1:0] : trial[nps_pkg::DivW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/nps_dpath.sv */
// Datapath: candidate, trial divisor, bound check, remainder unit, result register.
// Depends on nps_pkg and nps_rem_unit.
module nps_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nps_pkg::nps_cmd_t  cmd_i,
  output nps_pkg::nps_stat_t stat_o,
  input  nps_pkg::value_t    start_value_i,
  output nps_pkg::value_t    prime_o
);

  nps_pkg::value_t   cand_q;
  nps_pkg::divisor_t div_q;
  nps_pkg::value_t   out_q;

  logic [nps_pkg::SqW-1:0] div_sq;
  logic                    rem_done;
  nps_pkg::divisor_t       rem;

  // Candidate register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      cand_q <= start_value_i;
    end else if (cmd_i.next_cand) begin
      cand_q <= cand_q + 1'b1;
    end
  end

  // Odd trial divisor
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_div) begin
      div_q <= nps_pkg::FirstOddDiv;
    end else if (cmd_i.step_div) begin
      div_q <= div_q + nps_pkg::DivStep;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= cand_q;
    end
  end

  // Search ends once d*d passes the candidate
  assign div_sq = nps_pkg::SqW'(div_q) * nps_pkg::SqW'(div_q);

  nps_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_rem),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Status back to the controller
  always_comb begin
    stat_o.cand_lt2   = cand_q < nps_pkg::FirstPrime;
    stat_o.cand_is2   = cand_q == nps_pkg::FirstPrime;
    stat_o.cand_even  = ~cand_q[0];
    stat_o.over_bound = div_sq > {1'b0, cand_q};
    stat_o.rem_done   = rem_done;
    stat_o.rem_zero   = rem == '0;
  end

  assign prime_o = out_q;

endmodule

/* rtl/core/nps_ctrl.sv */
// Controller FSM: sequences candidate checks, trial divisions and result handoff.
// Depends on nps_pkg.
module nps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nps_pkg::nps_cmd_t  cmd_o,
  input  nps_pkg::nps_stat_t stat_i
);

  nps_pkg::nps_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nps_pkg::NpsIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      nps_pkg::NpsIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_start = 1'b1;
          state_d          = nps_pkg::NpsCheck;
        end
      end
      nps_pkg::NpsCheck: begin
        // 0 and 1 skip ahead; 2 is prime; other evens are composite
        priority if (stat_i.cand_lt2) begin
          cmd_o.next_cand = 1'b1;
        end else if (stat_i.cand_is2) begin
          state_d = nps_pkg::NpsFound;
        end else if (stat_i.cand_even) begin
          cmd_o.next_cand = 1'b1;
        end else begin
          cmd_o.init_div = 1'b1;
          state_d        = nps_pkg::NpsBound;
        end
      end
      nps_pkg::NpsBound: begin
        if (stat_i.over_bound) begin
          state_d = nps_pkg::NpsFound;
        end else begin
          cmd_o.start_rem = 1'b1;
          state_d         = nps_pkg::NpsDivide;
        end
      end
      nps_pkg::NpsDivide: begin
        if (stat_i.rem_done) begin
          if (stat_i.rem_zero) begin
            cmd_o.next_cand = 1'b1;
            state_d         = nps_pkg::NpsCheck;
          end else begin
            cmd_o.step_div = 1'b1;
            state_d        = nps_pkg::NpsBound;
          end
        end
      end
      nps_pkg::NpsFound: begin
        // Hand off once the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = nps_pkg::NpsIdle;
        end
      end
      default: begin
        state_d = nps_pkg::NpsIdle;
      end
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* bench/tb.sv */
// Self-checking bench for next_prime_search_top: trial-division predictor,
// directed and random start values, random idle cycles on both channels.
// Depends on nps_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;

  // One prime near 2^31 dominates the run time; everything else is small
  localparam int unsigned CycleLimit = 6_000_000;
  localparam int unsigned DrainWait  = 50;

  logic            clk            = 1'b0;
  logic            rst_n          = 1'b0;
  logic            in_valid       = 1'b0;
  nps_pkg::value_t in_start_value = '0;
  logic            out_stall      = 1'b0;
  logic            in_stall;
  logic            out_valid;
  nps_pkg::value_t out_prime;

  nps_pkg::value_t pending_primes[$];
  int unsigned     mismatches  = 0;
  int unsigned     cycle_count = 0;
  bit              no_idle     = 1'b0;

  next_prime_search_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_start_value_i (in_start_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_prime_o      (out_prime)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Trial division over odd divisors up to floor(sqrt(n))
  function automatic bit is_prime_value(input nps_pkg::value_t n);
    longint unsigned d;
    if (n < nps_pkg::FirstPrime) return 1'b0;
    if (n == nps_pkg::FirstPrime) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if ((n % d) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic nps_pkg::value_t expected_prime(input nps_pkg::value_t start);
    nps_pkg::value_t cand;
    cand = start;
    while (!is_prime_value(cand)) cand++;
    return cand;
  endfunction

  // Send one start value; valid stays high on return
  task automatic send_start(input nps_pkg::value_t value);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_primes.push_back(expected_prime(value));
  endtask

  // Result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_primes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item prime=%0d", $time, out_prime);
        end else begin
          if (out_prime !== pending_primes[0]) begin
            mismatches++;
            $display("%0t: prime expected %0d actual %0d",
                     $time, pending_primes[0], out_prime);
          end
          void'(pending_primes.pop_front());
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 8);
    end
  end

  // Zero and one are not prime; small composites and prime squares
  task automatic test_small_values();
    send_start(0);
    send_start(1);
    send_start(2);
    send_start(3);
    send_start(4);
    send_start(8);
    send_start(9);
    send_start(25);
    send_start(49);
    send_start(120);
  endtask

  // Start value already prime comes back unchanged
  task automatic test_known_primes();
    send_start(97);
    send_start(7919);
    send_start(65521);
    send_start(1000003);
  endtask

  // Longer runs of composites before the next prime
  task automatic test_prime_gaps();
    send_start(114);
    send_start(1328);
    send_start(31398);
    send_start(1042441);  // 1021 squared
  endtask

  // Largest start value sets every bit and is itself prime
  task automatic test_field_extremes();
    send_start(nps_pkg::value_t'(32'h7FFF_FFFF));
    send_start(0);
  endtask

  // Random start values, mostly narrow so the search stays short
  task automatic test_random_values(input int unsigned count);
    int unsigned     bits;
    nps_pkg::value_t value;
    for (int unsigned i = 0; i < count; i++) begin
      bits  = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      value = nps_pkg::value_t'($urandom) & nps_pkg::value_t'((32'd1 << bits) - 1);
      send_start(value);
    end
  endtask

  // Back-to-back items with neither side idling
  task automatic test_no_idle(input int unsigned count);
    no_idle = 1'b1;
    test_random_values(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_values();
    test_known_primes();
    test_prime_gaps();
    test_field_extremes();
    test_random_values(60);
    test_no_idle(20);
    test_random_values(20);

    in_valid <= 1'b0;
    wait (pending_primes.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && pending_primes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
